// File: sv/indexed_list_insert_erase_defines.svh
// Assertion macros shared by the list RTL
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

// Same-cycle implication, skipped while reset is high
`define ILIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high
`define ILIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ilie_pkg.sv
package ilie_pkg;

   // Fixed field widths of the item formats
   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Packed widths, rounded up to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_ERASE  = 3'd2,
      CMD_READ   = 3'd3,
      CMD_WRITE  = 3'd4
   } cmd_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_LOAD   = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_ERASE  = 2'd3
   } cell_op_type;

endpackage

// File: sv/ilie_cell.sv
module ilie_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 5
) (
   input  logic                        clock,
   input  ilie_pkg::cell_op_type       op,
   input  logic [CMP_W-1:0]            target,
   input  logic [ilie_pkg::DATA_W-1:0] value,
   input  logic [ilie_pkg::DATA_W-1:0] prev_data,
   input  logic [ilie_pkg::DATA_W-1:0] next_data,
   output logic [ilie_pkg::DATA_W-1:0] data
);
   import ilie_pkg::*;

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Pick the next entry: own value, new value or a neighbor's entry
   always_comb begin
      unique case (op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_LOAD: begin
            data_in = (IDX == target) ? value : data_ff;
         end
         CELL_INSERT: begin
            if (IDX == target) begin
               data_in = value;
            end else if (IDX > target) begin
               data_in = prev_data;
            end else begin
               data_in = data_ff;
            end
         end
         CELL_ERASE: begin
            data_in = (IDX >= target) ? next_data : data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Hold the entry
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: sv/indexed_list_insert_erase.sv
// Channel  | Direction | Payload
// req_*    | in        | tdata: command[2:0], position[7:3], value[39:8]
// rsp_*    | out       | tdata: read_value[31:0], count[36:32], status[38:37]
//
// One item per cycle: an accepted command updates the cell chain and the
// entry count in the same cycle, and its result sits in the output register.
// Insert and erase shift later entries by one place, all in parallel.
// The next item is taken while a result waits only if rsp_tready is high.
// Reset (synchronous, active high) empties the list and holds req_tready low;
// entries keep garbage.

`include "indexed_list_insert_erase_defines.svh"

module indexed_list_insert_erase #(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // command[2:0], position[7:3], value[39:8]
   input  logic [ilie_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_value[31:0], count[36:32], status[38:37], zeros above
   output logic [ilie_pkg::RSP_W-1:0] rsp_tdata
);
   import ilie_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // Registers
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   used_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic [RSP_W-1:0]   rsp_data_in;

   // Request fields
   cmd_type            cmd;
   logic [POS_W-1:0]   pos;
   logic [DATA_W-1:0]  val;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   used_ext;
   logic               accept;
   logic               full;

   // Command decode results
   cell_op_type        cell_op;
   logic [CMP_W-1:0]   cell_target;
   status_type         status;
   logic [DATA_W-1:0]  rd_value;
   logic [DATA_W-1:0]  rd_tap;

   logic [DATA_W-1:0]  cell_data [CAPACITY];

   assign cmd      = cmd_type'(req_tdata[CMD_W-1:0]);
   assign pos      = req_tdata[CMD_W +: POS_W];
   assign val      = req_tdata[CMD_W + POS_W +: DATA_W];
   assign pos_ext  = CMP_W'(pos);
   assign used_ext = CMP_W'(used_ff);
   assign full     = (used_ff == CAP_CNT);

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Select the entry at the requested position
   always_comb begin
      rd_tap = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CMP_W'(i) == pos_ext) begin
            rd_tap = rd_tap | cell_data[i];
         end
      end
   end

   // Decode the command into a chain operation, status, read value and new count
   always_comb begin
      cell_op     = CELL_HOLD;
      cell_target = pos_ext;
      status      = STAT_OK;
      rd_value    = '0;
      used_in     = used_ff;
      unique case (cmd)
         CMD_APPEND: begin
            if (full) begin
               status = STAT_FULL;
            end else begin
               cell_op     = CELL_LOAD;
               cell_target = used_ext;
               used_in     = used_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            if (pos_ext > used_ext) begin
               status = STAT_RANGE;
            end else if (full) begin
               status = STAT_FULL;
            end else begin
               cell_op = CELL_INSERT;
               used_in = used_ff + CNT_W'(1);
            end
         end
         CMD_ERASE: begin
            if (pos_ext >= used_ext) begin
               status = STAT_RANGE;
            end else begin
               cell_op = CELL_ERASE;
               used_in = used_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (pos_ext >= used_ext) begin
               status = STAT_RANGE;
            end else begin
               rd_value = rd_tap;
            end
         end
         CMD_WRITE: begin
            if (pos_ext >= used_ext) begin
               status = STAT_RANGE;
            end else begin
               cell_op = CELL_LOAD;
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
      if (!accept) begin
         cell_op = CELL_HOLD;
         used_in = used_ff;
      end
   end

   // Build the chain of cells, each fed by its neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] prev_w;
      logic [DATA_W-1:0] next_w;
      if (g == 0) begin : g_first
         assign prev_w = val;
      end else begin : g_mid
         assign prev_w = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_w = cell_data[g];
      end else begin : g_inner
         assign next_w = cell_data[g+1];
      end
      ilie_cell #(
         .INDEX (g),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .target    (cell_target),
         .value     (val),
         .prev_data (prev_w),
         .next_data (next_w),
         .data      (cell_data[g])
      );
   end

   // Next output register contents
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({status, COUNT_W'(used_in), rd_value});
      end
   end

   // Advance count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `ILIE_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff <= CAP_CNT,
      "entry count above capacity")
   `ILIE_ASSERT_NOW(a_full_only_when_full, clock, reset,
      accept && status == STAT_FULL, full && cell_op == CELL_HOLD,
      "full status while list has room")
   `ILIE_ASSERT_NEXT(a_grow_by_one, clock, reset,
      accept && (cell_op == CELL_INSERT || (cmd == CMD_APPEND && !full)),
      used_ff == $past(used_ff) + CNT_W'(1),
      "insert or append did not grow list by one")
   `ILIE_ASSERT_NEXT(a_erase_by_one, clock, reset,
      accept && cell_op == CELL_ERASE,
      used_ff == $past(used_ff) - CNT_W'(1),
      "erase did not shrink list by one")

endmodule

// File: sim/indexed_list_insert_erase_test.sv
`timescale 1ns / 100ps

module indexed_list_insert_erase_test;
   import ilie_pkg::*;

   localparam int          LIST_DEPTH   = 16;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam logic [2:0]  CMD_CODE_TOP = '1;
   localparam logic [4:0]  POS_TOP      = '1;
   localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX     = 32'h7fff_ffff;
   localparam logic [31:0] WORD_ONES    = '1;

   typedef struct packed {
      logic [DATA_W-1:0]  read_value;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } list_result_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   // command[2:0], position[7:3], value[39:8]
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // read_value[31:0], count[36:32], status[38:37], zeros above
   logic [RSP_W-1:0]  rsp_tdata;

   // Shadow list kept in step with every accepted item
   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int                list_used;
   list_result_type   pending_results [$];
   int                failures;
   int                sender_idle_pct;
   int                receiver_idle_pct;

   indexed_list_insert_erase #(
      .CAPACITY(LIST_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one command to the shadow list and return the result it must give
   function automatic list_result_type apply_list_command(logic [2:0] command,
                                                          logic [4:0] position,
                                                          logic [31:0] value);
      list_result_type result;
      int              pos;
      pos               = position;
      result.read_value = '0;
      result.status     = STAT_OK;
      case (command)
         CMD_APPEND: begin
            if (list_used >= LIST_DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               list_words[list_used] = value;
               list_used++;
            end
         end
         CMD_INSERT: begin
            // range is checked before fullness
            if (pos > list_used) begin
               result.status = STAT_RANGE;
            end else if (list_used >= LIST_DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               for (int i = list_used; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = value;
               list_used++;
            end
         end
         CMD_ERASE: begin
            if (pos >= list_used) begin
               result.status = STAT_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_used; i++) list_words[i] = list_words[i+1];
               list_used--;
            end
         end
         CMD_READ: begin
            if (pos >= list_used) result.status = STAT_RANGE;
            else result.read_value = list_words[pos];
         end
         CMD_WRITE: begin
            if (pos >= list_used) result.status = STAT_RANGE;
            else list_words[pos] = value;
         end
         default: begin
            // unused codes do nothing
         end
      endcase
      result.count = list_used[COUNT_W-1:0];
      return result;
   endfunction

   // Random word, with the extremes mixed in now and then
   function automatic logic [31:0] pick_word();
      case ($urandom_range(15, 0))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Offer one item after a random gap, hold it until taken, then predict
   task automatic send_command(input logic [2:0] command, input logic [4:0] position,
                               input logic [31:0] value);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, position, command};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(),
                             apply_list_command(command, position, value));
   endtask

   // Stop sending until every outstanding result has been checked
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Empty list refusals, both ends of the value range, positions at the limits
   task automatic test_empty_and_edges();
      send_command(CMD_READ, 5'd0, '0);
      send_command(CMD_ERASE, 5'd0, '0);
      send_command(CMD_WRITE, 5'd0, WORD_ONES);
      send_command(CMD_INSERT, 5'd1, WORD_ONES);
      send_command(CMD_INSERT, 5'd0, WORD_MIN);
      send_command(CMD_APPEND, 5'd0, WORD_MAX);
      send_command(CMD_INSERT, 5'd2, '0);
      send_command(CMD_INSERT, 5'd1, WORD_ONES);
      send_command(CMD_READ, 5'd3, '0);
      send_command(CMD_READ, 5'd4, '0);
      send_command(CMD_WRITE, 5'd0, 32'h5555_5555);
      send_command(CMD_READ, 5'd0, '0);
      send_command(CMD_ERASE, 5'd1, '0);
      send_command(CMD_ERASE, 5'd2, '0);
      send_command(CMD_READ, POS_TOP, '0);
      send_command(CMD_INSERT, POS_TOP, WORD_ONES);
      // unused command codes, all other bits high
      for (int c = int'(CMD_WRITE) + 1; c <= int'(CMD_CODE_TOP); c++)
         send_command(3'(c), POS_TOP, WORD_ONES);
   endtask

   // Fill the list, probe full and range refusals on a full list, then shrink from both ends
   task automatic test_full_list();
      while (list_used < LIST_DEPTH) send_command(CMD_APPEND, 5'd0, pick_word());
      send_command(CMD_APPEND, 5'd0, WORD_MAX);
      send_command(CMD_INSERT, 5'd0, WORD_MIN);
      send_command(CMD_INSERT, 5'(LIST_DEPTH), WORD_MIN);
      send_command(CMD_INSERT, 5'(LIST_DEPTH + 1), WORD_MIN);
      send_command(CMD_READ, 5'(LIST_DEPTH - 1), '0);
      send_command(CMD_WRITE, 5'(LIST_DEPTH - 1), WORD_MIN);
      send_command(CMD_READ, 5'(LIST_DEPTH - 1), '0);
      send_command(CMD_READ, 5'(LIST_DEPTH), '0);
      send_command(CMD_ERASE, 5'd0, '0);
      send_command(CMD_ERASE, 5'(LIST_DEPTH - 2), '0);
      send_command(CMD_READ, 5'd0, '0);
   endtask

   // Random traffic steered toward a moving fill level so the list sweeps
   // between empty and full; a small share is unconstrained noise
   task automatic test_random_traffic(input int item_total);
      int         fill_target;
      int         roll;
      logic [2:0] command;
      logic [4:0] position;
      fill_target = $urandom_range(LIST_DEPTH, 0);
      for (int n = 0; n < item_total; n++) begin
         if (list_used == fill_target && $urandom_range(7, 0) == 0) begin
            case ($urandom_range(3, 0))
               0:       fill_target = 0;
               1:       fill_target = LIST_DEPTH;
               default: fill_target = $urandom_range(LIST_DEPTH, 0);
            endcase
         end
         roll = $urandom_range(9, 0);
         if ($urandom_range(99, 0) < 8) begin
            command  = 3'($urandom);
            position = 5'($urandom);
         end else begin
            if (list_used < fill_target)
               command = (roll < 4) ? CMD_APPEND : (roll < 8) ? CMD_INSERT :
                         (roll < 9) ? CMD_READ : CMD_WRITE;
            else if (list_used > fill_target)
               command = (roll < 7) ? CMD_ERASE : (roll < 9) ? CMD_READ : CMD_WRITE;
            else
               command = (roll < 3) ? CMD_READ : (roll < 6) ? CMD_WRITE :
                         (roll < 8) ? CMD_INSERT : CMD_APPEND;
            // mostly in range, sometimes anywhere in the field
            if ($urandom_range(9, 0) == 0)
               position = 5'($urandom);
            else if (command == CMD_INSERT)
               position = 5'($urandom_range(list_used, 0));
            else if (list_used > 0)
               position = 5'($urandom_range(list_used - 1, 0));
            else
               position = '0;
         end
         send_command(command, position, pick_word());
      end
   endtask

   // Collect results, compare with the oldest prediction, stall at random
   initial begin
      list_result_type seen;
      list_result_type wanted;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.read_value = rsp_tdata[DATA_W-1:0];
            seen.count      = rsp_tdata[DATA_W +: COUNT_W];
            seen.status     = status_type'(rsp_tdata[DATA_W+COUNT_W +: STATUS_W]);
            if (pending_results.size() == 0) begin
               $error("result item arrived with none outstanding: %h", rsp_tdata);
               failures++;
            end else begin
               wanted = pending_results.pop_front();
               if (seen.read_value !== wanted.read_value) begin
                  $error("read_value: expected %h, actual %h", wanted.read_value,
                         seen.read_value);
                  failures++;
               end
               if (seen.count !== wanted.count) begin
                  $error("count: expected %0d, actual %0d", wanted.count, seen.count);
                  failures++;
               end
               if (seen.status !== wanted.status) begin
                  $error("status: expected %0d, actual %0d", wanted.status, seen.status);
                  failures++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   // Give up on a hang
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      failures          = 0;
      list_used         = 0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 82;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_edges();
      test_full_list();
      test_random_traffic(134);
      drain_results();

      sender_idle_pct   = 82;
      receiver_idle_pct = 34;
      test_random_traffic(133);
      drain_results();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_traffic(133);
      drain_results();

      // let any stray result show up
      repeat (4) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
